// ----- src/assert_macros.svh -----
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define DMP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by another in the next cycle.
`define DMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DMP_ASSERT(label, clk, rst_n, prop, msg)
`define DMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/dmp_pkg.sv -----
`timescale 1ns / 1ps
package dmp_pkg;

	// Default sizes.
	localparam int PACKET_BYTES_DEF   = 512;
	localparam int MAX_NAME_CHARS_DEF = 255;
	localparam int NAME_CAP_LIMIT     = 248;

	// Message layout constants.
	localparam logic [15:0] HEADER_BYTES = 16'd12;
	localparam logic [15:0] COMP_MARK    = 16'hC000;
	localparam logic [15:0] OFFSET_MASK  = 16'h3FFF;
	localparam logic [7:0]  LABEL_LIMIT  = 8'h80;
	localparam logic [7:0]  DOT_CHAR     = 8'h2E;

	// Store offsets reach 0x3FFF and one past it.
	localparam int PTR_W = 15;

	// Result kinds.
	localparam logic [4:0] K_HDR0   = 5'd0;
	localparam logic [4:0] K_QNAME  = 5'd6;
	localparam logic [4:0] K_QTYPE  = 5'd7;
	localparam logic [4:0] K_QCLASS = 5'd8;
	localparam logic [4:0] K_ANAME  = 5'd9;
	localparam logic [4:0] K_ATYPE  = 5'd10;
	localparam logic [4:0] K_ACLASS = 5'd11;
	localparam logic [4:0] K_TTL    = 5'd12;
	localparam logic [4:0] K_RDLEN  = 5'd13;
	localparam logic [4:0] K_RDATA  = 5'd14;
	localparam logic [4:0] K_ERROR  = 5'd15;
	localparam logic [4:0] K_DONE   = 5'd16;

	// Error codes.
	localparam logic [31:0] ERR_SHORT_HDR = 32'd1;
	localparam logic [31:0] ERR_LABEL     = 32'd2;
	localparam logic [31:0] ERR_NO_PTR    = 32'd3;
	localparam logic [31:0] ERR_EARLY_END = 32'd4;
	localparam logic [31:0] ERR_BAD_PTR   = 32'd5;

	// One result without its run flag.
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] value;
		logic [2:0]  char_count;
		logic [15:0] record_index;
	} res_t;

	// Place a name character into its byte lane of the packed word.
	function automatic logic [31:0] char_merge(logic [31:0] acc, logic [1:0] slot,
		logic [7:0] ch);
		char_merge = acc | ({24'b0, ch} << {slot, 3'b000});
	endfunction

endpackage

// ----- src/dmp_if.sv -----
`timescale 1ns / 1ps
// Message byte channel.
interface dmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;
	modport source(output valid, output data_byte, output end_of_packet, input ready);
	modport sink(input valid, input data_byte, input end_of_packet, output ready);
endinterface

// Parse result channel.
interface dmp_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic [31:0] value;
	logic [2:0]  char_count;
	logic [15:0] record_index;
	logic        last_of_run;
	modport source(output valid, output kind, output value, output char_count,
		output record_index, output last_of_run, input ready);
	modport sink(input valid, input kind, input value, input char_count,
		input record_index, input last_of_run, output ready);
endinterface

// ----- src/dmp_store.sv -----
`timescale 1ns / 1ps
// Packet byte store: one write port, one read port with registered data.
module dmp_store #(
	parameter int DEPTH = dmp_pkg::PACKET_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write the incoming byte.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/dns_message_parser_top.sv -----
`timescale 1ns / 1ps
// DNS message parser with compressed answer names.
// msg_in carries one message byte per beat, end_of_packet marking the last byte.
// res_out carries parse results: header words, question names, types and classes,
// expanded answer names, answer fields, RDATA bytes, an error or a done marker.
// last_of_run is set on the final result caused by one input byte.
// An ordinary byte is first accepted, then parsed in the E_MAIN state. Its
// results are held back in a pending register so that the last one can be
// flagged; that result moves on once the engine is idle and the output is free.
// A compressed answer name is expanded from the packet store, whose read data is
// registered: each label length or name byte is requested in X_LEN or X_CHR and
// used in X_LENW or X_CHRW; a label ends with one more X_CHR pass, a pointer hop
// also passes X_PTR and X_PTRW, and E_NTERM closes the name.
// Reset returns the parser to the header of a new message; the store needs no
// clearing, as only bytes already received in this message are read.
// When res_out stalls, the parser stops once one result is pending and one is
// on the output, and msg_in deasserts ready until the results drain.
`include "assert_macros.svh"

module dns_message_parser_top #(
	parameter int PACKET_BYTES   = dmp_pkg::PACKET_BYTES_DEF,
	parameter int MAX_NAME_CHARS = dmp_pkg::MAX_NAME_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dmp_in_if.sink     msg_in,
	dmp_out_if.source  res_out
);

	localparam int AW       = $clog2(PACKET_BYTES);
	localparam int NAME_CAP = (MAX_NAME_CHARS < dmp_pkg::NAME_CAP_LIMIT) ?
		MAX_NAME_CHARS : dmp_pkg::NAME_CAP_LIMIT;
	localparam int PW       = dmp_pkg::PTR_W;

	typedef enum logic [3:0] {
		PH_HDR, PH_QNAME, PH_QTYPE, PH_QCLASS, PH_ANAME, PH_ATYPE,
		PH_ACLASS, PH_TTL, PH_RDLEN, PH_RDATA, PH_IDLE
	} phase_t;

	typedef enum logic [3:0] {
		E_IDLE, E_MAIN, E_NTERM, E_FIN, E_EOP,
		X_LEN, X_LENW, X_PTR, X_PTRW, X_CHR, X_CHRW
	} eng_t;

	eng_t          eng_q;
	phase_t        phase_q;
	logic [15:0]   pos_q;
	logic [15:0]   cur_pos_q;
	logic [7:0]    byte_q;
	logic          eop_q;
	logic [15:0]   qtot_q;
	logic [15:0]   atot_q;
	logic [15:0]   rc_q;
	logic [7:0]    lr_q;
	logic          first_q;
	logic [31:0]   acc_q;
	logic [2:0]    fbl_q;
	logic [15:0]   rdrem_q;
	logic [7:0]    nc_q;
	logic [4:0]    nkind_q;
	logic [PW-1:0] p_q;
	logic [PW-1:0] bound_q;
	logic [5:0]    hi_q;

	dmp_pkg::res_t pend_q;
	logic          pend_v_q;
	dmp_pkg::res_t out_q;
	logic          out_last_q;
	logic          out_v_q;

	logic          out_free;
	logic          slot_ok;
	logic          accept;
	logic [15:0]   avail;
	logic [15:0]   p_ext;
	logic [7:0]    rdata;
	logic          rd_en;
	eng_t          end_st;

	// Handshake and staging.
	assign out_free = !out_v_q || res_out.ready;
	assign slot_ok  = !pend_v_q || out_free;
	assign msg_in.ready = (eng_q == E_IDLE) && slot_ok;
	assign accept   = msg_in.valid && msg_in.ready;
	assign end_st   = eop_q ? E_EOP : E_IDLE;

	// Bytes of this message that the store holds.
	assign avail = (pos_q < 16'(PACKET_BYTES)) ? pos_q : 16'(PACKET_BYTES);
	assign p_ext = 16'(p_q);
	assign rd_en = (eng_q == X_LEN) || (eng_q == X_PTR) || (eng_q == X_CHR);

	dmp_store #(
		.DEPTH(PACKET_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (accept && (pos_q < 16'(PACKET_BYTES))),
		.waddr(pos_q[AW-1:0]),
		.wdata(msg_in.data_byte),
		.re   (rd_en),
		.raddr(p_q[AW-1:0]),
		.rdata(rdata)
	);

	// Output register.
	assign res_out.valid        = out_v_q;
	assign res_out.kind         = out_q.kind;
	assign res_out.value        = out_q.value;
	assign res_out.char_count   = out_q.char_count;
	assign res_out.record_index = out_q.record_index;
	assign res_out.last_of_run  = out_last_q;

	// Parse engine, result staging and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		dmp_pkg::res_t g;
		logic          gv;
		logic [31:0]   fv;
		logic [31:0]   a;
		logic [2:0]    f;
		logic [15:0]   rcn;
		logic [7:0]    c;
		if (!arst_n) begin
			eng_q    <= E_IDLE;
			phase_q  <= PH_HDR;
			pos_q    <= '0;
			qtot_q   <= '0;
			atot_q   <= '0;
			rc_q     <= '0;
			lr_q     <= '0;
			first_q  <= 1'b1;
			acc_q    <= '0;
			fbl_q    <= '0;
			rdrem_q  <= '0;
			nc_q     <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			g   = '0;
			gv  = 1'b0;
			fv  = {acc_q[23:0], byte_q};
			f   = (fbl_q != 3'd0) ? fbl_q - 3'd1 : 3'd0;
			rcn = rc_q + 16'd1;
			c   = byte_q;
			a   = '0;

			if (accept) begin
				// Latch the byte and advance the position.
				byte_q    <= msg_in.data_byte;
				eop_q     <= msg_in.end_of_packet;
				cur_pos_q <= pos_q;
				if (pos_q != 16'hFFFF) begin
					pos_q <= pos_q + 16'd1;
				end
				eng_q <= E_MAIN;
			end else if (eng_q != E_IDLE && slot_ok) begin
				case (eng_q)
					E_MAIN: begin
						eng_q <= end_st;
						case (phase_q)
							PH_HDR: begin
								acc_q <= fv;
								if (cur_pos_q[0]) begin
									g = '{kind: dmp_pkg::K_HDR0 + 5'(cur_pos_q[3:1]),
										value: {16'b0, fv[15:0]}, char_count: 3'd0,
										record_index: 16'd0};
									gv = 1'b1;
									acc_q <= '0;
									if (cur_pos_q[3:1] == 3'd2) qtot_q <= fv[15:0];
									if (cur_pos_q[3:1] == 3'd3) atot_q <= fv[15:0];
									if (cur_pos_q + 16'd1 >= dmp_pkg::HEADER_BYTES) begin
										rc_q <= '0;
										if (qtot_q != 16'd0) begin
											phase_q <= PH_QNAME;
											fbl_q   <= '0;
											nc_q    <= '0;
											first_q <= 1'b1;
											lr_q    <= '0;
										end else if (atot_q == 16'd0) begin
											eng_q <= E_FIN;
										end else begin
											phase_q <= PH_ANAME;
											fbl_q   <= 3'd2;
										end
									end
								end
							end
							PH_QNAME: begin
								if (lr_q == 8'd0 && byte_q == 8'd0) begin
									nkind_q <= dmp_pkg::K_QNAME;
									eng_q   <= E_NTERM;
								end else if (lr_q == 8'd0 && byte_q >= dmp_pkg::LABEL_LIMIT) begin
									g = '{kind: dmp_pkg::K_ERROR, value: dmp_pkg::ERR_LABEL,
										char_count: 3'd0, record_index: rc_q};
									gv = 1'b1;
									phase_q <= PH_IDLE;
								end else begin
									if (lr_q == 8'd0) begin
										c = dmp_pkg::DOT_CHAR;
										first_q <= 1'b0;
										lr_q    <= byte_q;
									end else begin
										lr_q <= lr_q - 8'd1;
									end
									// Add one character unless the name is full or the byte opens the first label.
									if ((lr_q != 8'd0 || !first_q) && nc_q < 8'(NAME_CAP)) begin
										a = dmp_pkg::char_merge(acc_q, fbl_q[1:0], c);
										nc_q <= nc_q + 8'd1;
										if (fbl_q == 3'd3) begin
											g = '{kind: dmp_pkg::K_QNAME, value: a,
												char_count: 3'd4, record_index: rc_q};
											gv = 1'b1;
											acc_q <= '0;
											fbl_q <= '0;
										end else begin
											acc_q <= a;
											fbl_q <= fbl_q + 3'd1;
										end
									end
								end
							end
							PH_ANAME: begin
								if (fbl_q >= 3'd2) begin
									if (({byte_q, 8'h00} & dmp_pkg::COMP_MARK)
										!= dmp_pkg::COMP_MARK) begin
										g = '{kind: dmp_pkg::K_ERROR, value: dmp_pkg::ERR_NO_PTR,
											char_count: 3'd0, record_index: rc_q};
										gv = 1'b1;
										phase_q <= PH_IDLE;
									end else begin
										acc_q <= {24'b0, byte_q};
										fbl_q <= 3'd1;
									end
								end else begin
									// Start the expansion at the pointer target.
									p_q     <= PW'(fv[15:0] & dmp_pkg::OFFSET_MASK);
									bound_q <= PW'(fv[15:0] & dmp_pkg::OFFSET_MASK);
									acc_q   <= '0;
									fbl_q   <= '0;
									nc_q    <= '0;
									first_q <= 1'b1;
									lr_q    <= '0;
									nkind_q <= dmp_pkg::K_ANAME;
									eng_q   <= X_LEN;
								end
							end
							PH_QTYPE, PH_QCLASS, PH_ATYPE, PH_ACLASS, PH_TTL, PH_RDLEN: begin
								acc_q <= fv;
								fbl_q <= f;
								if (f == 3'd0) begin
									case (phase_q)
										PH_QTYPE: begin
											g = '{kind: dmp_pkg::K_QTYPE, value: {16'b0, fv[15:0]},
												char_count: 3'd0, record_index: rc_q};
											phase_q <= PH_QCLASS;
											acc_q   <= '0;
											fbl_q   <= 3'd2;
										end
										PH_QCLASS: begin
											g = '{kind: dmp_pkg::K_QCLASS, value: {16'b0, fv[15:0]},
												char_count: 3'd0, record_index: rc_q};
											rc_q <= rcn;
											if (rcn < qtot_q) begin
												phase_q <= PH_QNAME;
												acc_q   <= '0;
												fbl_q   <= '0;
												nc_q    <= '0;
												first_q <= 1'b1;
												lr_q    <= '0;
											end else begin
												rc_q <= '0;
												if (atot_q == 16'd0) begin
													eng_q <= E_FIN;
												end else begin
													phase_q <= PH_ANAME;
													acc_q   <= '0;
													fbl_q   <= 3'd2;
												end
											end
										end
										PH_ATYPE: begin
											g = '{kind: dmp_pkg::K_ATYPE, value: {16'b0, fv[15:0]},
												char_count: 3'd0, record_index: rc_q};
											phase_q <= PH_ACLASS;
											acc_q   <= '0;
											fbl_q   <= 3'd2;
										end
										PH_ACLASS: begin
											g = '{kind: dmp_pkg::K_ACLASS, value: {16'b0, fv[15:0]},
												char_count: 3'd0, record_index: rc_q};
											phase_q <= PH_TTL;
											acc_q   <= '0;
											fbl_q   <= 3'd4;
										end
										PH_TTL: begin
											g = '{kind: dmp_pkg::K_TTL, value: fv,
												char_count: 3'd0, record_index: rc_q};
											phase_q <= PH_RDLEN;
											acc_q   <= '0;
											fbl_q   <= 3'd2;
										end
										default: begin
											g = '{kind: dmp_pkg::K_RDLEN, value: {16'b0, fv[15:0]},
												char_count: 3'd0, record_index: rc_q};
											rdrem_q <= fv[15:0];
											if (fv[15:0] != 16'd0) begin
												phase_q <= PH_RDATA;
											end else begin
												rc_q <= rcn;
												if (rcn < atot_q) begin
													phase_q <= PH_ANAME;
													acc_q   <= '0;
													fbl_q   <= 3'd2;
												end else begin
													eng_q <= E_FIN;
												end
											end
										end
									endcase
									gv = 1'b1;
								end
							end
							PH_RDATA: begin
								g = '{kind: dmp_pkg::K_RDATA, value: {24'b0, byte_q},
									char_count: 3'd0, record_index: rc_q};
								gv = 1'b1;
								rdrem_q <= rdrem_q - 16'd1;
								if (rdrem_q <= 16'd1) begin
									rc_q <= rcn;
									if (rcn < atot_q) begin
										phase_q <= PH_ANAME;
										acc_q   <= '0;
										fbl_q   <= 3'd2;
									end else begin
										eng_q <= E_FIN;
									end
								end
							end
							default: begin
							end
						endcase
					end
					E_NTERM: begin
						// Flush a partial word, then the end-of-name beat.
						if (fbl_q != 3'd0) begin
							g = '{kind: nkind_q, value: acc_q, char_count: fbl_q,
								record_index: rc_q};
							acc_q <= '0;
							fbl_q <= '0;
						end else begin
							g = '{kind: nkind_q, value: 32'd0, char_count: 3'd0,
								record_index: rc_q};
							acc_q   <= '0;
							nc_q    <= '0;
							first_q <= 1'b1;
							lr_q    <= '0;
							fbl_q   <= 3'd2;
							phase_q <= (nkind_q == dmp_pkg::K_QNAME) ? PH_QTYPE : PH_ATYPE;
							eng_q   <= end_st;
						end
						gv = 1'b1;
					end
					E_FIN: begin
						g = '{kind: dmp_pkg::K_DONE, value: 32'd0, char_count: 3'd0,
							record_index: 16'd0};
						gv = 1'b1;
						phase_q <= PH_IDLE;
						eng_q   <= end_st;
					end
					E_EOP: begin
						if (phase_q != PH_IDLE) begin
							g = '{kind: dmp_pkg::K_ERROR,
								value: (phase_q == PH_HDR) ? dmp_pkg::ERR_SHORT_HDR :
									dmp_pkg::ERR_EARLY_END,
								char_count: 3'd0, record_index: rc_q};
							gv = 1'b1;
						end
						pos_q   <= '0;
						phase_q <= PH_HDR;
						qtot_q  <= '0;
						atot_q  <= '0;
						rc_q    <= '0;
						rdrem_q <= '0;
						acc_q   <= '0;
						fbl_q   <= '0;
						nc_q    <= '0;
						first_q <= 1'b1;
						lr_q    <= '0;
						eng_q   <= E_IDLE;
					end
					X_LEN: begin
						if (nc_q >= 8'(NAME_CAP)) begin
							eng_q <= E_NTERM;
						end else if (p_ext >= avail) begin
							g = '{kind: dmp_pkg::K_ERROR, value: dmp_pkg::ERR_BAD_PTR,
								char_count: 3'd0, record_index: rc_q};
							gv = 1'b1;
							phase_q <= PH_IDLE;
							eng_q   <= end_st;
						end else begin
							eng_q <= X_LENW;
						end
					end
					X_LENW: begin
						if (rdata == 8'd0) begin
							eng_q <= E_NTERM;
						end else if (rdata[7:6] == 2'b11) begin
							if (p_ext + 16'd1 >= avail) begin
								g = '{kind: dmp_pkg::K_ERROR, value: dmp_pkg::ERR_BAD_PTR,
									char_count: 3'd0, record_index: rc_q};
								gv = 1'b1;
								phase_q <= PH_IDLE;
								eng_q   <= end_st;
							end else begin
								hi_q  <= rdata[5:0];
								p_q   <= p_q + PW'(1);
								eng_q <= X_PTR;
							end
						end else if (rdata >= dmp_pkg::LABEL_LIMIT) begin
							g = '{kind: dmp_pkg::K_ERROR, value: dmp_pkg::ERR_LABEL,
								char_count: 3'd0, record_index: rc_q};
							gv = 1'b1;
							phase_q <= PH_IDLE;
							eng_q   <= end_st;
						end else begin
							// Label separator before every label but the first, while the name has room.
							if (!first_q && nc_q < 8'(NAME_CAP)) begin
								a = dmp_pkg::char_merge(acc_q, fbl_q[1:0], dmp_pkg::DOT_CHAR);
								nc_q <= nc_q + 8'd1;
								if (fbl_q == 3'd3) begin
									g = '{kind: dmp_pkg::K_ANAME, value: a, char_count: 3'd4,
										record_index: rc_q};
									gv = 1'b1;
									acc_q <= '0;
									fbl_q <= '0;
								end else begin
									acc_q <= a;
									fbl_q <= fbl_q + 3'd1;
								end
							end
							first_q <= 1'b0;
							p_q     <= p_q + PW'(1);
							lr_q    <= rdata;
							eng_q   <= X_CHR;
						end
					end
					X_PTR: begin
						eng_q <= X_PTRW;
					end
					X_PTRW: begin
						// Follow a pointer only backwards past the last target.
						if (PW'({hi_q, rdata}) >= bound_q) begin
							g = '{kind: dmp_pkg::K_ERROR, value: dmp_pkg::ERR_BAD_PTR,
								char_count: 3'd0, record_index: rc_q};
							gv = 1'b1;
							phase_q <= PH_IDLE;
							eng_q   <= end_st;
						end else begin
							bound_q <= PW'({hi_q, rdata});
							p_q     <= PW'({hi_q, rdata});
							eng_q   <= X_LEN;
						end
					end
					X_CHR: begin
						if (lr_q == 8'd0 || nc_q >= 8'(NAME_CAP)) begin
							eng_q <= X_LEN;
						end else if (p_ext >= avail) begin
							g = '{kind: dmp_pkg::K_ERROR, value: dmp_pkg::ERR_BAD_PTR,
								char_count: 3'd0, record_index: rc_q};
							gv = 1'b1;
							phase_q <= PH_IDLE;
							eng_q   <= end_st;
						end else begin
							eng_q <= X_CHRW;
						end
					end
					X_CHRW: begin
						a = dmp_pkg::char_merge(acc_q, fbl_q[1:0], rdata);
						nc_q <= nc_q + 8'd1;
						if (fbl_q == 3'd3) begin
							g = '{kind: dmp_pkg::K_ANAME, value: a, char_count: 3'd4,
								record_index: rc_q};
							gv = 1'b1;
							acc_q <= '0;
							fbl_q <= '0;
						end else begin
							acc_q <= a;
							fbl_q <= fbl_q + 3'd1;
						end
						p_q   <= p_q + PW'(1);
						lr_q  <= lr_q - 8'd1;
						eng_q <= X_CHR;
					end
					default: begin
						eng_q <= E_IDLE;
					end
				endcase
			end

			// A new result pushes the pending one out; an idle engine flushes it as last.
			if (gv) begin
				if (pend_v_q) begin
					out_q      <= pend_q;
					out_last_q <= 1'b0;
					out_v_q    <= 1'b1;
				end else if (res_out.ready) begin
					out_v_q <= 1'b0;
				end
				pend_q   <= g;
				pend_v_q <= 1'b1;
			end else if (eng_q == E_IDLE && pend_v_q && out_free) begin
				out_q      <= pend_q;
				out_last_q <= 1'b1;
				out_v_q    <= 1'b1;
				pend_v_q   <= 1'b0;
			end else if (res_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// A name never grows past its character limit.
	`DMP_ASSERT(a_name_cap, clk, arst_n, nc_q <= 8'(NAME_CAP), "name length past its limit")
	// A label length is only read from a byte of this message.
	`DMP_ASSERT(a_store_reach, clk, arst_n, (eng_q == X_LENW) |-> (p_ext < avail),
		"store read beyond received bytes")
	// A new byte starts with no result of the previous byte still pending.
	`DMP_ASSERT_NEXT(a_pend_clear, clk, arst_n, accept, !pend_v_q && eng_q == E_MAIN,
		"byte accepted over a pending result")

endmodule

// ----- tb/dmp_result_checker.sv -----
`timescale 1ns / 1ps
// Watches both channels of the parser, predicts the results of every accepted
// message byte and compares each result beat with the oldest expected one.
module dmp_result_checker (
	input  logic clk,
	input  logic arst_n,
	dmp_in_if    msg,
	dmp_out_if   res,
	output int   fail_count,
	output int   pending,
	output int   bytes_seen,
	output int   results_seen,
	output int   errors_seen
);
	import dmp_pkg::*;

	localparam int STORE_DEPTH = PACKET_BYTES_DEF;
	localparam int NAME_CAP    = (MAX_NAME_CHARS_DEF < NAME_CAP_LIMIT) ?
		MAX_NAME_CHARS_DEF : NAME_CAP_LIMIT;
	localparam int RUN_MAX     = 64;

	typedef enum logic [3:0] {
		PH_HEADER, PH_QNAME, PH_QTYPE, PH_QCLASS, PH_ANAME, PH_ATYPE,
		PH_ACLASS, PH_TTL, PH_RDLEN, PH_RDATA, PH_IDLE
	} phase_e;

	typedef struct packed {
		res_t fields;
		logic last;
	} beat_t;

	// Parser state as the predictor sees it.
	logic [7:0]  msg_store [STORE_DEPTH];
	logic [15:0] byte_pos;
	phase_e      phase;
	logic [15:0] question_cnt;
	logic [15:0] answer_cnt;
	logic [15:0] record_no;
	logic [7:0]  label_left;
	logic        first_label;
	logic [31:0] accum;
	logic [2:0]  accum_left;
	logic [15:0] rdata_left;
	int          name_len;

	// Results of the byte being predicted, then the queue of expected beats.
	res_t  run_buf [RUN_MAX];
	int    run_len;
	beat_t expected_beats [$];

	function automatic void add_result(logic [4:0] kind, logic [31:0] value,
		logic [2:0] cnt, logic [15:0] idx);
		if (run_len < RUN_MAX) begin
			run_buf[run_len] = '{kind: kind, value: value, char_count: cnt,
				record_index: idx};
			run_len++;
		end
	endfunction

	function automatic void begin_field(phase_e ph, logic [2:0] nbytes);
		phase = ph;
		accum = '0;
		accum_left = nbytes;
	endfunction

	function automatic void raise_error(logic [31:0] code);
		add_result(K_ERROR, code, 3'd0, record_no);
		phase = PH_IDLE;
	endfunction

	function automatic void clear_name();
		accum = '0;
		accum_left = '0;
		name_len = 0;
		first_label = 1'b1;
		label_left = '0;
	endfunction

	function automatic void push_char(logic [4:0] kind, logic [7:0] c);
		if (name_len >= NAME_CAP)
			return;
		accum = accum | (32'(c) << (8 * accum_left[1:0]));
		accum_left++;
		name_len++;
		if (accum_left >= 3'd4) begin
			add_result(kind, accum, 3'd4, record_no);
			accum = '0;
			accum_left = '0;
		end
	endfunction

	function automatic void close_name(logic [4:0] kind);
		if (accum_left > 0)
			add_result(kind, accum, accum_left, record_no);
		add_result(kind, 32'd0, 3'd0, record_no);
		clear_name();
	endfunction

	function automatic void advance_answer(logic first);
		if (first)
			record_no = '0;
		else
			record_no++;
		if (record_no < answer_cnt)
			begin_field(PH_ANAME, 3'd2);
		else begin
			add_result(K_DONE, 32'd0, 3'd0, 16'd0);
			phase = PH_IDLE;
		end
	endfunction

	// Follow a compressed name through the store; returns 0 on an error.
	function automatic logic expand_name(int start);
		int   avail;
		int   p;
		int   bound;
		int   len;
		int   target;
		int   j;
		avail = (byte_pos < STORE_DEPTH) ? byte_pos : STORE_DEPTH;
		p = start;
		bound = start;
		clear_name();
		while (1) begin
			if (name_len >= NAME_CAP)
				break;
			if (p >= avail) begin
				raise_error(ERR_BAD_PTR);
				return 1'b0;
			end
			len = msg_store[p];
			if (len == 0)
				break;
			if (len >= 8'hC0) begin
				if (p + 1 >= avail) begin
					raise_error(ERR_BAD_PTR);
					return 1'b0;
				end
				target = ((len & 8'h3F) << 8) | msg_store[p + 1];
				if (target >= bound) begin
					raise_error(ERR_BAD_PTR);
					return 1'b0;
				end
				bound = target;
				p = target;
				continue;
			end
			if (len >= LABEL_LIMIT) begin
				raise_error(ERR_LABEL);
				return 1'b0;
			end
			if (!first_label)
				push_char(K_ANAME, DOT_CHAR);
			first_label = 1'b0;
			p++;
			for (j = 0; j < len; j++) begin
				if (name_len >= NAME_CAP)
					break;
				if (p >= avail) begin
					raise_error(ERR_BAD_PTR);
					return 1'b0;
				end
				push_char(K_ANAME, msg_store[p]);
				p++;
			end
		end
		close_name(K_ANAME);
		return 1'b1;
	endfunction

	function automatic void reset_parse();
		byte_pos = '0;
		phase = PH_HEADER;
		question_cnt = '0;
		answer_cnt = '0;
		record_no = '0;
		rdata_left = '0;
		clear_name();
	endfunction

	// A fixed-width field has all its bytes.
	function automatic void field_complete(logic [31:0] v);
		case (phase)
			PH_QTYPE: begin
				add_result(K_QTYPE, {16'd0, v[15:0]}, 3'd0, record_no);
				begin_field(PH_QCLASS, 3'd2);
			end
			PH_QCLASS: begin
				add_result(K_QCLASS, {16'd0, v[15:0]}, 3'd0, record_no);
				record_no++;
				if (record_no < question_cnt) begin
					phase = PH_QNAME;
					clear_name();
				end else
					advance_answer(1'b1);
			end
			PH_ATYPE: begin
				add_result(K_ATYPE, {16'd0, v[15:0]}, 3'd0, record_no);
				begin_field(PH_ACLASS, 3'd2);
			end
			PH_ACLASS: begin
				add_result(K_ACLASS, {16'd0, v[15:0]}, 3'd0, record_no);
				begin_field(PH_TTL, 3'd4);
			end
			PH_TTL: begin
				add_result(K_TTL, v, 3'd0, record_no);
				begin_field(PH_RDLEN, 3'd2);
			end
			default: begin
				add_result(K_RDLEN, {16'd0, v[15:0]}, 3'd0, record_no);
				rdata_left = v[15:0];
				if (rdata_left == 0)
					advance_answer(1'b0);
				else
					phase = PH_RDATA;
			end
		endcase
	endfunction

	// Work out every result caused by one message byte.
	function automatic void predict_byte(logic [7:0] b, logic eop);
		int          pos;
		logic [2:0]  idx;
		logic [15:0] w;
		beat_t       bt;
		pos = byte_pos;
		run_len = 0;
		if (pos < STORE_DEPTH)
			msg_store[pos] = b;
		if (byte_pos != 16'hFFFF)
			byte_pos++;
		case (phase)
			PH_HEADER: begin
				accum = (accum << 8) | b;
				if (pos[0]) begin
					idx = pos[3:1];
					w = accum[15:0];
					add_result(K_HDR0 + idx, {16'd0, w}, 3'd0, 16'd0);
					accum = '0;
					if (idx == 3'd2)
						question_cnt = w;
					if (idx == 3'd3)
						answer_cnt = w;
					if (pos + 1 >= HEADER_BYTES) begin
						record_no = '0;
						if (question_cnt > 0) begin
							phase = PH_QNAME;
							clear_name();
						end else
							advance_answer(1'b1);
					end
				end
			end
			PH_QNAME: begin
				if (label_left == 0) begin
					if (b == 0) begin
						close_name(K_QNAME);
						begin_field(PH_QTYPE, 3'd2);
					end else if (b >= LABEL_LIMIT)
						raise_error(ERR_LABEL);
					else begin
						if (!first_label)
							push_char(K_QNAME, DOT_CHAR);
						first_label = 1'b0;
						label_left = b;
					end
				end else begin
					push_char(K_QNAME, b);
					label_left--;
				end
			end
			PH_ANAME: begin
				if (accum_left >= 3'd2) begin
					if (({b, 8'd0} & COMP_MARK) != COMP_MARK)
						raise_error(ERR_NO_PTR);
					else begin
						accum = {24'd0, b};
						accum_left = 3'd1;
					end
				end else if (expand_name(int'(((accum << 8) | b) & OFFSET_MASK)))
					begin_field(PH_ATYPE, 3'd2);
			end
			PH_QTYPE, PH_QCLASS, PH_ATYPE, PH_ACLASS, PH_TTL, PH_RDLEN: begin
				accum = (accum << 8) | b;
				if (accum_left > 0)
					accum_left--;
				if (accum_left == 0)
					field_complete(accum);
			end
			PH_RDATA: begin
				add_result(K_RDATA, {24'd0, b}, 3'd0, record_no);
				if (rdata_left > 0)
					rdata_left--;
				if (rdata_left == 0)
					advance_answer(1'b0);
			end
			default: ;
		endcase
		if (eop) begin
			if (phase != PH_IDLE)
				raise_error(phase == PH_HEADER ? ERR_SHORT_HDR : ERR_EARLY_END);
			reset_parse();
		end
		for (int i = 0; i < run_len; i++) begin
			bt.fields = run_buf[i];
			bt.last = (i == run_len - 1);
			expected_beats.push_back(bt);
		end
	endfunction

	// Predict on every accepted byte and compare every accepted result beat.
	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			reset_parse();
			expected_beats.delete();
			fail_count <= 0;
			bytes_seen <= 0;
			results_seen <= 0;
			errors_seen <= 0;
		end else begin
			if (msg.valid && msg.ready) begin
				predict_byte(msg.data_byte, msg.end_of_packet);
				bytes_seen <= bytes_seen + 1;
			end
			if (res.valid && res.ready) begin
				results_seen <= results_seen + 1;
				if (res.kind == K_ERROR)
					errors_seen <= errors_seen + 1;
				if (expected_beats.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result kind %0d value %h", $realtime,
							res.kind, res.value);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_beats.pop_front();
					if (res.kind !== want.fields.kind || res.value !== want.fields.value ||
						res.char_count !== want.fields.char_count ||
						res.record_index !== want.fields.record_index ||
						res.last_of_run !== want.last) begin
						if (fail_count < 10)
							$display("%0t: result mismatch expected %0d/%h/%0d/%0d/%0d got %0d/%h/%0d/%0d/%0d",
								$realtime, want.fields.kind, want.fields.value,
								want.fields.char_count, want.fields.record_index, want.last,
								res.kind, res.value, res.char_count, res.record_index,
								res.last_of_run);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = expected_beats.size();
endmodule

// ----- tb/dns_message_parser_top_tb.sv -----
`timescale 1ns / 1ps
// Sends whole DNS messages byte by byte, well formed and broken, with random
// gaps on both channels, and reports the verdict of the result checker.
module dns_message_parser_top_tb;
	import dmp_pkg::*;

	localparam int IDLE_LIMIT  = 6000;
	localparam int TOTAL_BYTES = 400;

	typedef enum int {
		MSG_GOOD, MSG_BAD_LABEL, MSG_NO_PTR, MSG_CUT_SHORT, MSG_FWD_PTR, MSG_NOISE
	} msg_style_e;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   bytes_seen;
	int   results_seen;
	int   errors_seen;
	int   idle_cycles;
	int   messages_sent;
	logic long_hold;
	logic no_gaps;

	logic [7:0] msg_bytes [$];
	int         name_offsets [$];

	dmp_in_if  msg ();
	dmp_out_if res ();

	dns_message_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg_in (msg),
		.res_out(res)
	);

	dmp_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg         (msg),
		.res         (res),
		.fail_count  (fail_count),
		.pending     (pending),
		.bytes_seen  (bytes_seen),
		.results_seen(results_seen),
		.errors_seen (errors_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void put16(logic [15:0] v);
		msg_bytes.push_back(v[15:8]);
		msg_bytes.push_back(v[7:0]);
	endfunction

	// Build one message; long_label gives a question name past the name cap,
	// trailer adds ignored bytes after the parsed sections.
	function automatic void build_message(msg_style_e style, int qd, int an,
		logic long_label, int trailer);
		int nlabels;
		int len;
		int rdlen;
		int target;
		msg_bytes.delete();
		name_offsets.delete();
		put16(16'($urandom));
		put16(16'($urandom));
		put16(16'(qd));
		put16(16'(an));
		put16(16'($urandom_range(0, 3)));
		put16(16'($urandom));
		for (int q = 0; q < qd; q++) begin
			name_offsets.push_back(msg_bytes.size());
			nlabels = long_label ? 4 : $urandom_range(1, 3);
			for (int l = 0; l < nlabels; l++) begin
				len = long_label ? 62 : $urandom_range(1, 7);
				if (style == MSG_BAD_LABEL && q == qd - 1 && l == nlabels - 1)
					msg_bytes.push_back(8'h80 | 8'($urandom));
				else
					msg_bytes.push_back(8'(len));
				for (int c = 0; c < len; c++)
					msg_bytes.push_back(8'($urandom));
			end
			msg_bytes.push_back(8'd0);
			put16(16'($urandom));
			put16(16'($urandom));
		end
		for (int a = 0; a < an; a++) begin
			if (name_offsets.size() > 0)
				target = name_offsets[$urandom_range(0, name_offsets.size() - 1)];
			else
				target = $urandom_range(0, 11);
			if (style == MSG_FWD_PTR && a == an - 1)
				target = ($urandom_range(0, 1) != 0) ? msg_bytes.size() : 16'h3FFF;
			name_offsets.push_back(msg_bytes.size());
			if (style == MSG_NO_PTR && a == an - 1)
				put16(16'($urandom_range(0, 16'hBFFF)));
			else
				put16(COMP_MARK | 16'(target));
			put16(16'($urandom));
			put16(16'($urandom));
			put16(16'($urandom));
			put16(16'($urandom));
			rdlen = $urandom_range(0, 5);
			put16(16'(rdlen));
			for (int r = 0; r < rdlen; r++)
				msg_bytes.push_back(8'($urandom));
		end
		for (int t = 0; t < trailer; t++)
			msg_bytes.push_back(8'($urandom));
		if (style == MSG_NOISE) begin
			msg_bytes.delete();
			repeat ($urandom_range(1, 40))
				msg_bytes.push_back(8'($urandom));
		end
		if (style == MSG_CUT_SHORT && msg_bytes.size() > 1)
			msg_bytes = msg_bytes[0 : $urandom_range(0, msg_bytes.size() - 2)];
	endfunction

	// Offer each byte of the built message, the last with end_of_packet.
	task automatic send_message();
		int gap;
		for (int i = 0; i < msg_bytes.size(); i++) begin
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				msg.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			msg.valid <= 1'b1;
			msg.data_byte <= msg_bytes[i];
			msg.end_of_packet <= (i == msg_bytes.size() - 1);
			do
				@(posedge clk);
			while (!msg.ready);
		end
		msg.valid <= 1'b0;
		messages_sent++;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Result side: random stalls per beat, and on request one long hold-off.
	initial begin
		int gap;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				res.ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res.valid);
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((msg.valid && msg.ready) || (res.valid && res.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("status: fail");
			$finish;
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		msg.valid <= 1'b0;
		msg.data_byte <= '0;
		msg.end_of_packet <= 1'b0;
		long_hold = 1'b0;
		no_gaps = 1'b0;
		messages_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages: empty sections, a name past the name limit with the
		// result side held off, a bad label, a missing pointer, a bad pointer and a short header.
		build_message(MSG_GOOD, 0, 0, 1'b0, 0);
		send_message();
		long_hold = 1'b1;
		build_message(MSG_GOOD, 1, 1, 1'b1, 0);
		send_message();
		drain();
		build_message(MSG_BAD_LABEL, 1, 0, 1'b0, 0);
		send_message();
		build_message(MSG_NO_PTR, 0, 1, 1'b0, 0);
		send_message();
		build_message(MSG_FWD_PTR, 0, 1, 1'b0, 0);
		send_message();
		msg_bytes = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
		send_message();
		drain();

		// Random messages, half of them well formed, the rest broken or noise.
		while (bytes_seen < TOTAL_BYTES) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: build_message(MSG_BAD_LABEL, $urandom_range(1, 2), $urandom_range(0, 2),
					1'b0, 0);
				1: build_message(MSG_NO_PTR, $urandom_range(0, 2), $urandom_range(1, 2),
					1'b0, 0);
				2: build_message(MSG_CUT_SHORT, $urandom_range(0, 2), $urandom_range(0, 2),
					1'b0, 0);
				3: build_message(MSG_FWD_PTR, $urandom_range(0, 2), $urandom_range(1, 2),
					1'b0, 0);
				4: build_message(MSG_NOISE, 0, 0, 1'b0, 0);
				default: build_message(MSG_GOOD, $urandom_range(0, 2), $urandom_range(0, 3),
					1'b0, $urandom_range(0, 3));
			endcase
			send_message();
			if ($urandom_range(0, 5) == 0)
				drain();
		end
		no_gaps = 1'b0;

		drain();
		repeat (40) @(posedge clk);
		$display("%0d messages, %0d bytes in, %0d results checked, %0d of them errors",
			messages_sent, bytes_seen, results_seen, errors_seen);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
